@@ rtl/rchs_pkg.sv @@
// Package: widths, pipeline types, max-channel codes and the divider step function.
`default_nettype none

package rchs_pkg;

    localparam int IN_W   = 16;   // raw channel width
    localparam int CH_W   = 8;    // clamped channel width
    localparam int WORD_W = 32;   // packed RGBA word
    localparam int HUE_W  = 9;
    localparam int SAT_W  = 7;
    localparam int QW     = 9;    // quotient bits per divide
    localparam int NUM_W  = 18;   // dividend width
    localparam int DEN_W  = 9;    // divisor width
    localparam int QSTEP  = 3;    // quotient bits resolved per stage

    localparam logic [CH_W-1:0]  C_CH_MAX    = 8'd255;
    localparam logic [HUE_W-1:0] C_FULL_TURN = 9'd360;

    // Which channel holds the maximum
    localparam logic [1:0] MAX_RED   = 2'd0;
    localparam logic [1:0] MAX_GREEN = 2'd1;
    localparam logic [1:0] MAX_BLUE  = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] a;
    } t_rgba;

    typedef struct packed {
        t_rgba           px;
        logic [CH_W-1:0] mx;
        logic [CH_W-1:0] d;
        logic [1:0]      sel;
    } t_ext;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QW-1:0]    q;
    } t_div;

    typedef struct packed {
        t_rgba px;
        t_div  hue;
        t_div  sat;
        logic  grey;
        logic  black;
    } t_dst;

    typedef struct packed {
        t_rgba             px;
        logic [HUE_W-1:0]  hue;
        logic [SAT_W-1:0]  sat;
    } t_res;

    // Three restoring-division steps, quotient bits hi..hi-2
    function automatic t_div div_step3(input t_div x, input int hi);
        t_div             y;
        logic [NUM_W-1:0] trial;
        int               bit_i;
        y = x;
        for (int k = 0; k < QSTEP; k++) begin
            bit_i = hi - k;
            trial = NUM_W'({{(NUM_W-DEN_W){1'b0}}, y.den} << bit_i);
            if (y.rem >= trial) begin
                y.rem      = y.rem - trial;
                y.q[bit_i] = 1'b1;
            end
        end
        return y;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rchs_if.sv @@
// Stream interfaces: raw RGBA pixel in, clamped pixel with hue/saturation out.
`default_nettype none

interface rchs_in_if;
    import rchs_pkg::*;
    logic              valid;
    logic              ready;
    logic [IN_W-1:0]   red_in;
    logic [IN_W-1:0]   green_in;
    logic [IN_W-1:0]   blue_in;
    logic [IN_W-1:0]   alpha_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output alpha_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input alpha_in, output ready);
endinterface

interface rchs_out_if;
    import rchs_pkg::*;
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   red_out;
    logic [CH_W-1:0]   green_out;
    logic [CH_W-1:0]   blue_out;
    logic [CH_W-1:0]   alpha_out;
    logic [WORD_W-1:0] packed_word;
    logic [HUE_W-1:0]  hue_degrees;
    logic [SAT_W-1:0]  saturation_hundredths;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output alpha_out, output packed_word, output hue_degrees,
                    output saturation_hundredths, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input alpha_out, input packed_word, input hue_degrees,
                    input saturation_hundredths, output ready);
endinterface

`default_nettype wire

@@ rtl/rgba_clamp_hue_saturation_top.sv @@
// Top level: RGBA clamp with HSV hue and saturation, six-stage pipeline.
//
// Usage:
//   i_pix  - sink of raw pixels: four signed 16-bit channels per transaction.
//   o_res  - source of results: clamped channels, packed RGBA word, hue in
//            degrees (0..359) and saturation in hundredths (0..100).
//   Both channels use valid/ready; a transaction completes when both are high.
//   Path: an accepted transaction loads the first of six register stages at the
//   accepting edge and moves on stage by stage to o_res.valid.
//   Throughput: one pixel per clock unless stalled (see Stall); the two 9-bit
//   restoring dividers (hue and saturation) are spread over three stages, three
//   quotient bits each, so each pipeline stage can take a new pixel every cycle.
//   Reset (i_rst_n low, synchronous) clears all stage valid bits; payload
//   registers are not reset. The block holds no other state.
//   Stall: when o_res.ready is low, the output stage holds its result and
//   earlier stages keep filling any empty slot; i_pix.ready drops only when
//   every stage holds a pixel. Nothing is lost or repeated.
`default_nettype none

module rgba_clamp_hue_saturation_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    rchs_in_if.sink    i_pix,
    rchs_out_if.source o_res
);
    import rchs_pkg::*;

    localparam int STG = 6;

    // Stage valid bits and load enables; a stage loads when it is empty or
    // its content moves on in the same cycle.
    logic [STG-1:0] r_vld;
    logic [STG-1:0] w_en;

    t_rgba r_s1;    // clamped channels
    t_ext  r_s2;    // max, delta, max-channel code
    t_dst  r_s3;    // dividends/divisors set up
    t_dst  r_s4;    // quotient bits 8..6
    t_dst  r_s5;    // quotient bits 5..3
    t_res  r_s6;    // final result

    always_comb begin
        w_en[STG-1] = !r_vld[STG-1] || o_res.ready;
        for (int k = STG-2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_pix.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < STG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---- Stage 1: clamp each signed channel to 0..255
    function automatic logic [CH_W-1:0] clamp(input logic [IN_W-1:0] v);
        logic [CH_W-1:0] c;
        if (v[IN_W-1]) begin
            c = '0;                         // negative
        end else if (|v[IN_W-2:CH_W]) begin
            c = C_CH_MAX;                   // above 255
        end else begin
            c = v[CH_W-1:0];
        end
        return c;
    endfunction

    t_rgba n_s1;
    always_comb begin
        n_s1.r = clamp(i_pix.red_in);
        n_s1.g = clamp(i_pix.green_in);
        n_s1.b = clamp(i_pix.blue_in);
        n_s1.a = clamp(i_pix.alpha_in);
    end

    // ---- Stage 2: max, min, delta; red wins ties over green, green over blue
    t_ext            n_s2;
    logic [CH_W-1:0] w_mn;
    always_comb begin
        n_s2.px = r_s1;
        if (r_s1.r >= r_s1.g && r_s1.r >= r_s1.b) begin
            n_s2.sel = MAX_RED;
            n_s2.mx  = r_s1.r;
        end else if (r_s1.g >= r_s1.b) begin
            n_s2.sel = MAX_GREEN;
            n_s2.mx  = r_s1.g;
        end else begin
            n_s2.sel = MAX_BLUE;
            n_s2.mx  = r_s1.b;
        end
        w_mn = r_s1.r;
        if (r_s1.g < w_mn) w_mn = r_s1.g;
        if (r_s1.b < w_mn) w_mn = r_s1.b;
        n_s2.d = n_s2.mx - w_mn;
    end

    // ---- Stage 3: hue = (2*num + d) / (2*d), sat = (200*d + mx) / (2*mx)
    t_dst               n_s3;
    logic signed [19:0] w_diff;
    logic signed [19:0] w_prod;
    logic signed [19:0] w_dw;
    logic signed [19:0] w_num;
    logic signed [19:0] w_nh;
    always_comb begin
        w_dw = signed'({12'd0, r_s2.d});
        case (r_s2.sel)
            MAX_RED:   w_diff = signed'({12'd0, r_s2.px.g}) - signed'({12'd0, r_s2.px.b});
            MAX_GREEN: w_diff = signed'({12'd0, r_s2.px.b}) - signed'({12'd0, r_s2.px.r});
            default:   w_diff = signed'({12'd0, r_s2.px.r}) - signed'({12'd0, r_s2.px.g});
        endcase
        w_prod = w_diff * 20'sd60;
        case (r_s2.sel)
            MAX_RED:   w_num = w_prod + ((w_prod < 0) ? w_dw * 20'sd360 : 20'sd0);
            MAX_GREEN: w_num = w_prod + w_dw * 20'sd120;
            default:   w_num = w_prod + w_dw * 20'sd240;
        endcase
        w_nh = (w_num <<< 1) + w_dw;

        n_s3.px      = r_s2.px;
        n_s3.hue.rem = w_nh[NUM_W-1:0];
        n_s3.hue.den = {r_s2.d, 1'b0};
        n_s3.hue.q   = '0;
        n_s3.sat.rem = NUM_W'({10'd0, r_s2.d} * 18'd200) + NUM_W'({10'd0, r_s2.mx});
        n_s3.sat.den = {r_s2.mx, 1'b0};
        n_s3.sat.q   = '0;
        n_s3.grey    = (r_s2.d == '0);
        n_s3.black   = (r_s2.mx == '0);
    end

    // ---- Stages 4 and 5: three quotient bits each
    t_dst n_s4;
    t_dst n_s5;
    always_comb begin
        n_s4     = r_s3;
        n_s4.hue = div_step3(r_s3.hue, QW-1);
        n_s4.sat = div_step3(r_s3.sat, QW-1);
        n_s5     = r_s4;
        n_s5.hue = div_step3(r_s4.hue, QW-1-QSTEP);
        n_s5.sat = div_step3(r_s4.sat, QW-1-QSTEP);
    end

    // ---- Stage 6: last three bits, then grey/black and full-turn fix-up
    t_res n_s6;
    t_div w_hq;
    t_div w_sq;
    always_comb begin
        w_hq    = div_step3(r_s5.hue, QW-1-2*QSTEP);
        w_sq    = div_step3(r_s5.sat, QW-1-2*QSTEP);
        n_s6.px = r_s5.px;
        if (r_s5.grey || w_hq.q == C_FULL_TURN) begin
            n_s6.hue = '0;
        end else begin
            n_s6.hue = w_hq.q;
        end
        n_s6.sat = r_s5.black ? '0 : w_sq.q[SAT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) r_s1 <= n_s1;
        if (w_en[1]) r_s2 <= n_s2;
        if (w_en[2]) r_s3 <= n_s3;
        if (w_en[3]) r_s4 <= n_s4;
        if (w_en[4]) r_s5 <= n_s5;
        if (w_en[5]) r_s6 <= n_s6;
    end

    assign o_res.valid                 = r_vld[STG-1];
    assign o_res.red_out               = r_s6.px.r;
    assign o_res.green_out             = r_s6.px.g;
    assign o_res.blue_out              = r_s6.px.b;
    assign o_res.alpha_out             = r_s6.px.a;
    assign o_res.packed_word           = {r_s6.px.r, r_s6.px.g, r_s6.px.b, r_s6.px.a};
    assign o_res.hue_degrees           = r_s6.hue;
    assign o_res.saturation_hundredths = r_s6.sat;

endmodule

`default_nettype wire
